/* src/fifo_free_list_slot_allocator_defines.svh */
`ifndef FIFO_FREE_LIST_SLOT_ALLOCATOR_DEFINES_SVH
`define FIFO_FREE_LIST_SLOT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FFLSA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define FFLSA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/fflsa_pkg.sv */
`timescale 1ns / 1ps

package fflsa_pkg;

	localparam int SLOTS  = 1024;
	localparam int IDX_W  = $clog2(SLOTS);
	localparam int CNT_W  = IDX_W + 1;
	localparam int LINK_W = 32;
	localparam int TAG_W  = LINK_W - 1;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;

	localparam logic [LINK_W-1:0] FREE_MASK = {1'b1, {(LINK_W-1){1'b0}}};
	localparam logic [LINK_W-1:0] END_MARK  = '1;
	localparam logic [CNT_W-1:0]  SLOT_LIMIT_RST = CNT_W'(SLOTS);

	// Register index, taken from paddr[2].
	localparam logic REG_SLOT_LIMIT = 1'b0;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_FULL   = 2'd1,
		STAT_DOUBLE = 2'd2,
		STAT_RANGE  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_LINK
	} state_t;

	typedef struct packed {
		logic accept;
		logic exec;
		logic link;
	} cmd_t;

	typedef struct packed {
		logic need_link;
		logic out_blocked;
	} sts_t;

endpackage

/* src/fflsa_ctrl.sv */
`timescale 1ns / 1ps

module fflsa_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  fflsa_pkg::sts_t sts,
	output fflsa_pkg::cmd_t cmd
);
	import fflsa_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// Hold until the output register can take the result.
				if (!sts.out_blocked) begin
					state_d = sts.need_link ? ST_LINK : ST_IDLE;
				end
			end
			ST_LINK: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			ST_EXEC: begin
				cmd.exec = !sts.out_blocked;
			end
			ST_LINK: begin
				cmd.link = 1'b1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

/* src/fflsa_dp.sv */
`timescale 1ns / 1ps

module fflsa_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fflsa_pkg::cmd_t             cmd,
	output fflsa_pkg::sts_t             sts,
	input  logic [fflsa_pkg::CNT_W-1:0] slot_limit,
	input  logic                        op,
	input  logic [fflsa_pkg::IDX_W-1:0] slot_in,
	input  logic [fflsa_pkg::TAG_W-1:0] tag,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [fflsa_pkg::IDX_W-1:0] slot_out,
	output logic                        recycled,
	output logic [1:0]                  status,
	output logic [fflsa_pkg::CNT_W-1:0] free_count,
	output logic [fflsa_pkg::CNT_W-1:0] used_count
);
	import fflsa_pkg::*;

	`include "fifo_free_list_slot_allocator_defines.svh"

	logic [LINK_W-1:0] mem [SLOTS];

	logic              op_q;
	logic [IDX_W-1:0]  sidx_q;
	logic [TAG_W-1:0]  tag_q;
	logic [LINK_W-1:0] rd_q;
	logic [IDX_W-1:0]  head_q, tail_q, link_addr_q;
	logic              empty_q;
	logic [CNT_W-1:0]  wm_q, ft_q;

	logic              out_valid_q;
	logic [IDX_W-1:0]  slot_out_q;
	logic              recycled_q;
	status_t           status_q;
	logic [CNT_W-1:0]  free_count_q, used_count_q;

	logic [IDX_W-1:0]  head_d, tail_d, raddr;
	logic              empty_d;
	logic [CNT_W-1:0]  wm_d, ft_d;
	logic              exec_we, mem_we, need_link;
	logic [IDX_W-1:0]  exec_waddr, waddr;
	logic [LINK_W-1:0] exec_wdata, wdata;
	logic [IDX_W-1:0]  res_slot;
	logic              res_rec;
	status_t           res_status;

	assign raddr = (op == OP_FREE) ? slot_in : head_q;

	// Decision for the captured request, using the link word read at accept.
	always_comb begin
		head_d     = head_q;
		tail_d     = tail_q;
		empty_d    = empty_q;
		wm_d       = wm_q;
		ft_d       = ft_q;
		exec_we    = 1'b0;
		exec_waddr = sidx_q;
		exec_wdata = END_MARK;
		need_link  = 1'b0;
		res_slot   = '0;
		res_rec    = 1'b0;
		res_status = STAT_OK;
		if (op_q == OP_ALLOC) begin
			if (!empty_q) begin
				res_slot   = head_q;
				res_rec    = 1'b1;
				exec_we    = 1'b1;
				exec_waddr = head_q;
				exec_wdata = {1'b0, tag_q};
				if (ft_q != '0) begin
					ft_d = ft_q - CNT_W'(1);
				end
				if (rd_q == END_MARK) begin
					empty_d = 1'b1;
					head_d  = '0;
					tail_d  = '0;
				end else begin
					head_d = rd_q[IDX_W-1:0];
				end
			end else if (wm_q >= slot_limit || wm_q >= CNT_W'(SLOTS)) begin
				res_status = STAT_FULL;
			end else begin
				res_slot   = wm_q[IDX_W-1:0];
				exec_we    = 1'b1;
				exec_waddr = wm_q[IDX_W-1:0];
				exec_wdata = {1'b0, tag_q};
				wm_d       = wm_q + CNT_W'(1);
			end
		end else begin
			res_slot = sidx_q;
			if ({1'b0, sidx_q} >= wm_q) begin
				res_status = STAT_RANGE;
			end else if (rd_q[LINK_W-1]) begin
				res_status = STAT_DOUBLE;
			end else begin
				exec_we    = 1'b1;
				exec_waddr = sidx_q;
				exec_wdata = END_MARK;
				// The old tail gets its forward link in the following cycle.
				need_link  = !empty_q;
				if (empty_q) begin
					head_d = sidx_q;
				end
				tail_d  = sidx_q;
				empty_d = 1'b0;
				ft_d    = ft_q + CNT_W'(1);
			end
		end
	end

	assign mem_we = (cmd.exec && exec_we) || cmd.link;
	assign waddr  = cmd.link ? link_addr_q : exec_waddr;
	assign wdata  = cmd.link ? (FREE_MASK | LINK_W'(sidx_q)) : exec_wdata;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.accept) begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= op;
			sidx_q <= slot_in;
			tag_q  <= tag;
		end
		if (cmd.exec) begin
			link_addr_q  <= tail_q;
			slot_out_q   <= res_slot;
			recycled_q   <= res_rec;
			status_q     <= res_status;
			free_count_q <= ft_d;
			used_count_q <= wm_d - ft_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			empty_q     <= 1'b1;
			wm_q        <= '0;
			ft_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				head_q  <= head_d;
				tail_q  <= tail_d;
				empty_q <= empty_d;
				wm_q    <= wm_d;
				ft_q    <= ft_d;
			end
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.need_link   = need_link;
	assign sts.out_blocked = out_valid_q && out_stall;

	assign out_valid  = out_valid_q;
	assign slot_out   = slot_out_q;
	assign recycled   = recycled_q;
	assign status     = 2'(status_q);
	assign free_count = free_count_q;
	assign used_count = used_count_q;

	`FFLSA_ASSERT_NOW(a_free_within_top, 1'b1, ft_q <= wm_q, "free count exceeds watermark")
	`FFLSA_ASSERT_NOW(a_empty_no_free, empty_q, ft_q == '0, "empty list with nonzero free count")
	`FFLSA_ASSERT_NOW(a_no_overwrite, cmd.exec, !(out_valid_q && out_stall), "result register overwritten")
	`FFLSA_ASSERT_NOW(a_link_after_free, cmd.link, $past(cmd.exec && need_link), "tail link without a free")

endmodule

/* src/fifo_free_list_slot_allocator.sv */
`timescale 1ns / 1ps

// Slot allocator over a 1024-entry link memory with a FIFO free list. An allocate
// takes the oldest freed slot, else the next slot at the watermark up to slot_limit,
// and writes the tag into it; a free is checked against the watermark and for a double
// free, then linked at the tail. Every request gives exactly one result. One request is
// in work at a time: an allocate or a rejected free goes from acceptance via the execute
// state to the output register; a free onto a non-empty list holds the input through
// the link state too, as the link memory has one write port and that free writes two
// entries. A result held by out_stall blocks the next result, not the next acceptance.
module fifo_free_list_slot_allocator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         op,
	input  logic [fflsa_pkg::IDX_W-1:0]  slot_in,
	input  logic [fflsa_pkg::TAG_W-1:0]  tag,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [fflsa_pkg::IDX_W-1:0]  slot_out,
	output logic                         recycled,
	output logic [1:0]                   status,
	output logic [fflsa_pkg::CNT_W-1:0]  free_count,
	output logic [fflsa_pkg::CNT_W-1:0]  used_count,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [fflsa_pkg::ADDR_W-1:0] paddr,
	input  logic [fflsa_pkg::DATA_W-1:0] pwdata,
	output logic [fflsa_pkg::DATA_W-1:0] prdata,
	output logic                         pready
);
	import fflsa_pkg::*;

	logic [CNT_W-1:0] slot_limit_q;
	logic             reg_sel;
	cmd_t             cmd;
	sts_t             sts;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_SLOT_LIMIT);
	assign prdata  = reg_sel ? DATA_W'(slot_limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_limit_q <= SLOT_LIMIT_RST;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			slot_limit_q <= pwdata[CNT_W-1:0];
		end
	end

	fflsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	fflsa_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.slot_limit (slot_limit_q),
		.op         (op),
		.slot_in    (slot_in),
		.tag        (tag),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.slot_out   (slot_out),
		.recycled   (recycled),
		.status     (status),
		.free_count (free_count),
		.used_count (used_count)
	);

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

	import fflsa_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [IDX_W-1:0] slot;
		logic             recycled;
		status_t          status;
		logic [CNT_W-1:0] free_count;
		logic [CNT_W-1:0] used_count;
	} slot_result_t;

	typedef struct packed {
		logic             op;
		logic [IDX_W-1:0] idx;
		logic [TAG_W-1:0] tg;
		logic             known;
		slot_result_t     exp_res;
	} stim_row_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic                op;
	logic [IDX_W-1:0]    slot_in;
	logic [TAG_W-1:0]    tag;
	logic                out_valid;
	logic                out_stall;
	logic [IDX_W-1:0]    slot_out;
	logic                recycled;
	logic [1:0]          status;
	logic [CNT_W-1:0]    free_count;
	logic [CNT_W-1:0]    used_count;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	// Allocator state as the testbench sees it.
	logic [LINK_W-1:0]   link_mem [SLOTS];
	logic [IDX_W-1:0]    free_head;
	logic [IDX_W-1:0]    free_tail;
	logic                free_empty;
	logic [CNT_W-1:0]    watermark;
	logic [CNT_W-1:0]    free_total;
	logic [CNT_W-1:0]    slot_limit;

	slot_result_t        pending_results [$];
	stim_row_t           directed_rows [$];
	logic                drv_known;
	slot_result_t        drv_exp;
	bit                  calm;
	int                  mismatches;
	int                  cycle_count;
	int                  items_taken;
	int                  results_seen;
	int                  recycled_total;
	int                  status_tally [4];

	fifo_free_list_slot_allocator DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.slot_in    (slot_in),
		.tag        (tag),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.slot_out   (slot_out),
		.recycled   (recycled),
		.status     (status),
		.free_count (free_count),
		.used_count (used_count),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	task automatic report_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
		$display("mismatch at cycle %0d: %s expected 0x%0h got 0x%0h",
			cycle_count, what, exp_v, got_v);
		mismatches++;
	endtask

	// One allocate or free applied to the tracked state; returns what the block must report.
	function automatic slot_result_t predict_step(logic op_i, logic [IDX_W-1:0] idx,
			logic [TAG_W-1:0] tg);
		slot_result_t      r;
		logic [LINK_W-1:0] word;
		r = '0;
		if (op_i == OP_ALLOC) begin
			if (!free_empty) begin
				r.slot = free_head;
				r.recycled = 1'b1;
				word = link_mem[free_head];
				if (free_total != 0)
					free_total--;
				if (word == END_MARK) begin
					free_empty = 1'b1;
					free_head = '0;
					free_tail = '0;
				end else begin
					free_head = word[IDX_W-1:0];
				end
				link_mem[r.slot] = {1'b0, tg};
			end else if (watermark >= slot_limit || watermark >= SLOTS) begin
				r.status = STAT_FULL;
			end else begin
				r.slot = watermark[IDX_W-1:0];
				watermark++;
				link_mem[r.slot] = {1'b0, tg};
			end
		end else begin
			r.slot = idx;
			if ({1'b0, idx} >= watermark) begin
				r.status = STAT_RANGE;
			end else if (link_mem[idx][LINK_W-1]) begin
				r.status = STAT_DOUBLE;
			end else begin
				link_mem[idx] = END_MARK;
				if (!free_empty)
					link_mem[free_tail] = FREE_MASK | LINK_W'(idx);
				else
					free_head = idx;
				free_tail = idx;
				free_empty = 1'b0;
				free_total++;
			end
		end
		r.free_count = free_total;
		r.used_count = watermark - free_total;
		return r;
	endfunction

	// Seeks a used (or free, for a double free) slot below the watermark; else any slot.
	function automatic logic [IDX_W-1:0] pick_slot(logic want_free);
		int unsigned cand;
		for (int k = 0; k < 16; k++) begin
			if (watermark == 0)
				break;
			cand = $urandom_range(32'(watermark) - 1);
			if (link_mem[cand][LINK_W-1] == want_free)
				return cand[IDX_W-1:0];
		end
		return IDX_W'($urandom_range(SLOTS - 1));
	endfunction

	always @(negedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 11);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("run timed out after %0d cycles with %0d results pending",
				cycle_count, pending_results.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Output checking first, then prediction for an input transaction taken at this edge.
	always @(posedge clk) begin
		slot_result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					report_mismatch("result with nothing pending, slot_out", '0,
						32'(slot_out));
				end else begin
					want = pending_results.pop_front();
					if (slot_out !== want.slot)
						report_mismatch("slot_out", 32'(want.slot), 32'(slot_out));
					if (recycled !== want.recycled)
						report_mismatch("recycled", 32'(want.recycled), 32'(recycled));
					if (status !== want.status)
						report_mismatch("status", 32'(want.status), 32'(status));
					if (free_count !== want.free_count)
						report_mismatch("free_count", 32'(want.free_count),
							32'(free_count));
					if (used_count !== want.used_count)
						report_mismatch("used_count", 32'(want.used_count),
							32'(used_count));
				end
			end
			if (in_valid && !in_stall) begin
				want = predict_step(op, slot_in, tag);
				if (drv_known)
					want = drv_exp;
				pending_results.push_back(want);
				items_taken++;
				status_tally[want.status]++;
				if (want.recycled)
					recycled_total++;
			end
		end
	end

	task automatic send_item(logic o, logic [IDX_W-1:0] s, logic [TAG_W-1:0] t,
			logic known, slot_result_t ex);
		int gap;
		@(negedge clk);
		gap = (!calm && $urandom_range(99) < 11) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		slot_in <= s;
		tag <= t;
		drv_known <= known;
		drv_exp <= ex;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic apb_access(logic wr, logic [DATA_W-1:0] wdata,
			output logic [DATA_W-1:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {REG_SLOT_LIMIT, 2'b00};
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// The limit only changes once the block has drained every outstanding transaction.
	task automatic set_limit(logic [CNT_W-1:0] value);
		logic [DATA_W-1:0] rd;
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		apb_access(1'b1, DATA_W'(value), rd);
		slot_limit = value;
		apb_access(1'b0, '0, rd);
		if (rd[CNT_W-1:0] !== value)
			report_mismatch("slot_limit readback", 32'(value), rd);
	endtask

	task automatic add_row(logic o, logic [IDX_W-1:0] s, logic [TAG_W-1:0] t, logic known,
			logic [IDX_W-1:0] slot, logic rec, status_t st, int fc, int uc);
		stim_row_t row;
		row.op = o;
		row.idx = s;
		row.tg = t;
		row.known = known;
		row.exp_res.slot = slot;
		row.exp_res.recycled = rec;
		row.exp_res.status = st;
		row.exp_res.free_count = CNT_W'(fc);
		row.exp_res.used_count = CNT_W'(uc);
		directed_rows.push_back(row);
	endtask

	// With fill set, allocations dominate until the watermark reaches the slot count.
	task automatic run_random(int count, int alloc_pct, bit fill, int calm_from, int calm_to);
		logic             o;
		logic [IDX_W-1:0] s;
		int               pct;
		int               pick;
		for (int n = 0; n < count; n++) begin
			calm = (n >= calm_from && n < calm_to);
			pct = (fill && watermark < SLOTS) ? 92 : alloc_pct;
			o = ($urandom_range(99) < pct) ? OP_ALLOC : OP_FREE;
			pick = $urandom_range(99);
			if (o == OP_ALLOC)
				s = IDX_W'($urandom_range(SLOTS - 1));
			else if (pick < 78)
				s = pick_slot(1'b0);
			else if (pick < 88)
				s = pick_slot(1'b1);
			else
				s = IDX_W'($urandom_range(SLOTS - 1));
			send_item(o, s, TAG_W'($urandom_range(32'h7FFF_FFFE)), 1'b0, '0);
		end
		calm = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_ALLOC;
		slot_in = '0;
		tag = '0;
		out_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		drv_known = 1'b0;
		drv_exp = '0;
		calm = 1'b0;
		mismatches = 0;
		cycle_count = 0;
		items_taken = 0;
		results_seen = 0;
		recycled_total = 0;
		foreach (status_tally[i])
			status_tally[i] = 0;
		foreach (link_mem[i])
			link_mem[i] = '0;
		free_head = '0;
		free_tail = '0;
		free_empty = 1'b1;
		watermark = '0;
		free_total = '0;
		slot_limit = SLOT_LIMIT_RST;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// Rows marked known carry their result; the rest are checked against the tracked state.
		add_row(OP_FREE,  10'd0,    31'h7FFF_FFFF, 1'b1, 10'd0,    1'b0, STAT_RANGE,  0, 0);
		add_row(OP_FREE,  10'd1023, 31'h0,         1'b1, 10'd1023, 1'b0, STAT_RANGE,  0, 0);
		add_row(OP_ALLOC, 10'd1023, 31'h0,         1'b1, 10'd0,    1'b0, STAT_OK,     0, 1);
		add_row(OP_ALLOC, 10'd0,    31'h7FFF_FFFE, 1'b1, 10'd1,    1'b0, STAT_OK,     0, 2);
		add_row(OP_ALLOC, 10'd0,    31'h2AAA_AAAA, 1'b1, 10'd0,    1'b0, STAT_FULL,   0, 2);
		add_row(OP_FREE,  10'd1,    31'h0,         1'b1, 10'd1,    1'b0, STAT_OK,     1, 1);
		add_row(OP_FREE,  10'd1,    31'h0,         1'b1, 10'd1,    1'b0, STAT_DOUBLE, 1, 1);
		add_row(OP_FREE,  10'd2,    31'h0,         1'b1, 10'd2,    1'b0, STAT_RANGE,  1, 1);
		add_row(OP_FREE,  10'd0,    31'h0,         1'b0, 10'd0,    1'b0, STAT_OK,     0, 0);
		add_row(OP_ALLOC, 10'd1023, 31'h5555_5555, 1'b0, 10'd0,    1'b0, STAT_OK,     0, 0);
		add_row(OP_ALLOC, 10'd0,    31'h1555_5555, 1'b0, 10'd0,    1'b0, STAT_OK,     0, 0);
		add_row(OP_ALLOC, 10'd0,    31'h0000_0001, 1'b1, 10'd0,    1'b0, STAT_FULL,   0, 2);
		add_row(OP_FREE,  10'd0,    31'h0,         1'b0, 10'd0,    1'b0, STAT_OK,     0, 0);
		add_row(OP_ALLOC, 10'd0,    31'h3C3C_3C3C, 1'b0, 10'd0,    1'b0, STAT_OK,     0, 0);
		add_row(OP_FREE,  10'd1,    31'h0,         1'b0, 10'd0,    1'b0, STAT_OK,     0, 0);
		add_row(OP_FREE,  10'd0,    31'h0,         1'b0, 10'd0,    1'b0, STAT_OK,     0, 0);
		add_row(OP_FREE,  10'd1,    31'h0,         1'b0, 10'd0,    1'b0, STAT_OK,     0, 0);
		add_row(OP_ALLOC, 10'd0,    31'h4321_0FED, 1'b0, 10'd0,    1'b0, STAT_OK,     0, 0);
		add_row(OP_FREE,  10'd0,    31'h0,         1'b0, 10'd0,    1'b0, STAT_OK,     0, 0);
		add_row(OP_ALLOC, 10'd0,    31'h0ABC_DEF0, 1'b0, 10'd0,    1'b0, STAT_OK,     0, 0);
		add_row(OP_FREE,  10'd512,  31'h0,         1'b0, 10'd0,    1'b0, STAT_OK,     0, 0);
		add_row(OP_FREE,  10'd341,  31'h0,         1'b0, 10'd0,    1'b0, STAT_OK,     0, 0);

		set_limit(CNT_W'(2));
		foreach (directed_rows[i])
			send_item(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].tg,
				directed_rows[i].known, directed_rows[i].exp_res);

		set_limit(CNT_W'(1));
		run_random(80, 50, 1'b0, -1, -1);
		set_limit(CNT_W'(0));
		run_random(40, 50, 1'b0, -1, -1);
		set_limit(CNT_W'(48));
		run_random(450, 55, 1'b0, -1, -1);
		set_limit(CNT_W'(SLOTS));
		run_random(1330, 50, 1'b1, 400, 650);

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("covered %0d transactions over slot limits 2, 1, 0, 48 and %0d; %0d recycled",
			items_taken, SLOTS, recycled_total);
		$display("status mix ok/full/double/range: %0d/%0d/%0d/%0d, final watermark %0d",
			status_tally[STAT_OK], status_tally[STAT_FULL], status_tally[STAT_DOUBLE],
			status_tally[STAT_RANGE], watermark);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
